@@ sv/rgbpwm_pkg.sv @@
package rgbpwm_pkg;

	localparam int NUM_LEDS  = 64;
	localparam int LED_W     = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam int MEM_DEPTH = 2 ** (LED_W + 1);
	localparam int COLOR_W   = 24;
	localparam int DUTY_W    = 16;
	localparam int SLOT_W    = 8;
	localparam int BITPOS_W  = 5;
	localparam logic [BITPOS_W-1:0] BIT_TOP = 5'd23;

	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_TICK  = 2'd2;

	localparam logic [2:0] CFG_DUTY_ONE   = 3'd0;
	localparam logic [2:0] CFG_DUTY_ZERO  = 3'd1;
	localparam logic [2:0] CFG_DUTY_FINAL = 3'd2;
	localparam logic [2:0] CFG_LEAD       = 3'd3;
	localparam logic [2:0] CFG_TRAIL      = 3'd4;

	typedef enum logic [1:0] {
		PH_LEAD  = 2'd0,
		PH_BITS  = 2'd1,
		PH_TRAIL = 2'd2,
		PH_FINAL = 2'd3
	} phase_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty_one;
		logic [DUTY_W-1:0] duty_zero;
		logic [DUTY_W-1:0] duty_final;
		logic [SLOT_W-1:0] lead;
		logic [SLOT_W-1:0] trail;
	} cfg_t;

	typedef struct packed {
		logic               en;
		logic [LED_W-1:0]   idx;
		logic [COLOR_W-1:0] data;
	} wr_t;

	typedef struct packed {
		logic              valid;
		logic [DUTY_W-1:0] duty;
		logic              last;
	} slot_res_t;

endpackage

@@ sv/rgbpwm_store.sv @@
module rgbpwm_store import rgbpwm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  wr_t                wr,
	input  logic               start,
	input  logic [LED_W-1:0]   led_d,
	input  logic [LED_W-1:0]   led_q,
	output logic [COLOR_W-1:0] word
);

	// two banks per LED; the frame snapshot is a copy of the bank-select bits
	logic [COLOR_W-1:0]  mem [MEM_DEPTH];
	logic [NUM_LEDS-1:0] color_vld_q;
	logic [NUM_LEDS-1:0] color_sel_q;
	logic [NUM_LEDS-1:0] frame_vld_q;
	logic [NUM_LEDS-1:0] frame_sel_q;
	logic [COLOR_W-1:0]  rdata_q;
	logic                wr_bank;
	logic                rd_bank;

	assign wr_bank = ~frame_sel_q[wr.idx];
	assign rd_bank = start ? color_sel_q[led_d] : frame_sel_q[led_d];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[{wr_bank, wr.idx}] <= wr.data;
		end
		rdata_q <= mem[{rd_bank, led_d}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_vld_q <= '0;
			color_sel_q <= '0;
			frame_vld_q <= '0;
			frame_sel_q <= '0;
		end else begin
			if (wr.en) begin
				color_vld_q[wr.idx] <= 1'b1;
				color_sel_q[wr.idx] <= wr_bank;
			end
			if (start) begin
				frame_vld_q <= color_vld_q;
				frame_sel_q <= color_sel_q;
			end
		end
	end

	assign word = frame_vld_q[led_q] ? rdata_q : '0;

endmodule

@@ sv/rgbpwm_seq.sv @@
module rgbpwm_seq import rgbpwm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               start,
	input  logic               tick,
	input  logic [COLOR_W-1:0] word,
	output logic               busy_q,
	output logic               busy_d,
	output logic [LED_W-1:0]   led_q,
	output logic [LED_W-1:0]   led_d,
	output slot_res_t          res
);

	phase_t              phase_q, phase_d;
	logic [SLOT_W-1:0]   slot_q, slot_d;
	logic [BITPOS_W-1:0] bit_q, bit_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= PH_LEAD;
			slot_q  <= '0;
			led_q   <= '0;
			bit_q   <= BIT_TOP;
		end else begin
			busy_q  <= busy_d;
			phase_q <= phase_d;
			slot_q  <= slot_d;
			led_q   <= led_d;
			bit_q   <= bit_d;
		end
	end

	always_comb begin
		phase_t            ph;
		logic [SLOT_W-1:0] slot;
		busy_d  = busy_q;
		phase_d = phase_q;
		slot_d  = slot_q;
		led_d   = led_q;
		bit_d   = bit_q;
		res     = '0;
		ph      = phase_q;
		slot    = slot_q;
		if (start) begin
			busy_d  = 1'b1;
			phase_d = PH_LEAD;
			slot_d  = '0;
			led_d   = '0;
			bit_d   = BIT_TOP;
		end else if (tick && busy_q) begin
			res.valid = 1'b1;
			if (ph == PH_LEAD && slot >= cfg.lead) begin
				ph   = PH_BITS;
				slot = '0;
			end
			if (ph == PH_TRAIL && slot >= cfg.trail) begin
				ph   = PH_FINAL;
				slot = '0;
			end
			phase_d = ph;
			slot_d  = slot;
			unique case (ph)
				PH_LEAD, PH_TRAIL: begin
					slot_d = slot + 1'b1;
				end
				PH_BITS: begin
					res.duty = word[bit_q] ? cfg.duty_one : cfg.duty_zero;
					if (bit_q == '0) begin
						bit_d = BIT_TOP;
						if (led_q == LED_W'(NUM_LEDS - 1)) begin
							led_d   = '0;
							phase_d = PH_TRAIL;
							slot_d  = '0;
						end else begin
							led_d = led_q + 1'b1;
						end
					end else begin
						bit_d = bit_q - 1'b1;
					end
				end
				PH_FINAL: begin
					// after the trail run the trail check moves straight into the final slot
					res.duty = cfg.duty_final;
					res.last = 1'b1;
					busy_d   = 1'b0;
					phase_d  = PH_LEAD;
					slot_d   = '0;
					led_d    = '0;
					bit_d    = BIT_TOP;
				end
				default: begin
					phase_d = PH_LEAD;
				end
			endcase
		end
	end

endmodule

@@ sv/rgb_led_pwm_frame_encoder.sv @@
// A result word is registered as its input word is accepted, valid the cycle after.
// Throughput: one word per cycle unless out_ready stalls; a start latches the
// whole frame at once by copying per-LED bank-select bits, with two banks per
// LED in one RAM. Reset (asynchronous, active low): idle, counters cleared,
// registers to defaults, all LEDs read as off until written; no clearing pass.
module rgb_led_pwm_frame_encoder import rgbpwm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [DUTY_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        kind,
	input  logic [6:0]        led_number,
	input  logic [7:0]        red,
	input  logic [7:0]        green,
	input  logic [7:0]        blue,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              accepted,
	output logic              duty_valid,
	output logic [DUTY_W-1:0] duty,
	output logic              last_slot,
	output logic              busy_res
);

	cfg_t             cfg_q;
	wr_t              wr;
	slot_res_t        res;
	logic             in_fire;
	logic             in_range;
	logic             start;
	logic             tick;
	logic             busy_q;
	logic             busy_d;
	logic [LED_W-1:0] led_q;
	logic [LED_W-1:0] led_d;
	logic [COLOR_W-1:0] word;
	logic             out_valid_q;
	logic             accepted_q;
	logic             duty_valid_q;
	logic [DUTY_W-1:0] duty_q;
	logic             last_slot_q;
	logic             busy_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.duty_one   <= 16'd87;
			cfg_q.duty_zero  <= 16'd48;
			cfg_q.duty_final <= 16'd255;
			cfg_q.lead       <= 8'd20;
			cfg_q.trail      <= 8'd60;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DUTY_ONE:   cfg_q.duty_one   <= cfg_data;
				CFG_DUTY_ZERO:  cfg_q.duty_zero  <= cfg_data;
				CFG_DUTY_FINAL: cfg_q.duty_final <= cfg_data;
				CFG_LEAD:       cfg_q.lead       <= cfg_data[SLOT_W-1:0];
				CFG_TRAIL:      cfg_q.trail      <= cfg_data[SLOT_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;
	assign in_range = (led_number != 7'd0) && (9'(led_number) <= 9'(NUM_LEDS));
	assign start    = in_fire && (kind == KIND_START) && !busy_q;
	assign tick     = in_fire && (kind == KIND_TICK);

	assign wr.en   = in_fire && (kind == KIND_WRITE) && in_range;
	assign wr.idx  = LED_W'(led_number - 7'd1);
	assign wr.data = {red, green, blue};

	rgbpwm_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.start  (start),
		.led_d  (led_d),
		.led_q  (led_q),
		.word   (word)
	);

	rgbpwm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.start  (start),
		.tick   (tick),
		.word   (word),
		.busy_q (busy_q),
		.busy_d (busy_d),
		.led_q  (led_q),
		.led_d  (led_d),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			accepted_q   <= wr.en || start;
			duty_valid_q <= res.valid;
			duty_q       <= res.duty;
			last_slot_q  <= res.last;
			busy_res_q   <= busy_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign accepted   = accepted_q;
	assign duty_valid = duty_valid_q;
	assign duty       = duty_q;
	assign last_slot  = last_slot_q;
	assign busy_res   = busy_res_q;

endmodule
